// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the header decoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, reset-gated.
`define MAHD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("%m: property failed");

// A stalled valid must still be up in the next cycle.
`define MAHD_ASSERT_HOLD(lbl, clk, rstn, vld, rdy) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) ((vld) && !(rdy)) |=> (vld)) \
		else $error("%m: valid dropped while stalled");

`endif

// ----- hw/rtl/mahd_pkg.sv -----
// ---------------------------------------------------------------------------
// mahd_pkg
// Types, codes and tables for the MPEG audio frame header decoder.
// ---------------------------------------------------------------------------
package mahd_pkg;

	// version field codes
	localparam logic [1:0] VER_25   = 2'd0;
	localparam logic [1:0] VER_RSVD = 2'd1;
	localparam logic [1:0] VER_2    = 2'd2;
	localparam logic [1:0] VER_1    = 2'd3;

	// layer field code that is reserved
	localparam logic [1:0] LC_RSVD = 2'd0;

	// bitrate / sample-rate index codes that reject the word
	localparam logic [3:0] BRI_FREE = 4'd0;
	localparam logic [3:0] BRI_BAD  = 4'd15;
	localparam logic [1:0] SRI_RSVD = 2'd3;

	// channel mode code for single channel
	localparam logic [1:0] MODE_MONO = 2'd3;

	// layer numbers
	localparam logic [1:0] LAYER_1 = 2'd1;
	localparam logic [1:0] LAYER_3 = 2'd3;

	// reciprocal scaling: quotient = (n * recip) >> RECIP_SH, one correction
	localparam int RECIP_SH = 24;
	localparam int NUM_W    = 18;
	localparam int RECIP_W  = 25;
	localparam int PROD_W   = NUM_W + RECIP_W;
	localparam int QUO_W    = 12;

	// [mpeg1][layer-1][bitrate index]
	localparam logic [8:0] BR_TAB [0:1][0:2][0:15] = '{
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
		},
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
		}
	};

	localparam logic [15:0] SR_BASE [0:3] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};

	// divisor left after the rate ratio is reduced
	typedef enum logic [2:0] {
		DIV_1,
		DIV_2,
		DIV_4,
		DIV_8,
		DIV_49,
		DIV_147
	} div_sel_t;

	// decoded header, as it travels from front to back
	typedef struct packed {
		logic              ok;
		logic [1:0]        layer;
		logic [1:0]        version;
		logic              crc;
		logic [8:0]        br;
		logic [15:0]       sr;
		logic              pad;
		logic [1:0]        mode;
		logic [1:0]        modeext;
		logic [1:0]        chans;
		logic [10:0]       spf;
		logic [NUM_W-1:0]  num;
		div_sel_t          dsel;
		logic              l1;
		logic              half;
	} item_t;

	function automatic logic [7:0] div_val(div_sel_t d);
		unique case (d)
			DIV_1:   div_val = 8'd1;
			DIV_2:   div_val = 8'd2;
			DIV_4:   div_val = 8'd4;
			DIV_8:   div_val = 8'd8;
			DIV_49:  div_val = 8'd49;
			DIV_147: div_val = 8'd147;
			default: div_val = 8'd1;
		endcase
	endfunction

	// floor(2^24 / d)
	function automatic logic [RECIP_W-1:0] div_recip(div_sel_t d);
		unique case (d)
			DIV_1:   div_recip = 25'd16777216;
			DIV_2:   div_recip = 25'd8388608;
			DIV_4:   div_recip = 25'd4194304;
			DIV_8:   div_recip = 25'd2097152;
			DIV_49:  div_recip = 25'd342392;
			DIV_147: div_recip = 25'd114130;
			default: div_recip = 25'd16777216;
		endcase
	endfunction

endpackage

// ----- hw/rtl/mahd_if.sv -----
// ---------------------------------------------------------------------------
// mahd_if
// Valid/ready channels for header words in and decoded results out.
// ---------------------------------------------------------------------------
interface mahd_hdr_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;

	modport source(output valid, output header_word, input ready);
	modport sink(input valid, input header_word, output ready);
endinterface

interface mahd_res_if;
	logic        valid;
	logic        ready;
	logic        valid_res;
	logic [1:0]  layer_num;
	logic [1:0]  version_code;
	logic        crc_present;
	logic [8:0]  bitrate_kbps;
	logic [15:0] sample_rate_hz;
	logic        padded;
	logic [1:0]  channel_mode;
	logic [1:0]  mode_extension;
	logic [1:0]  channel_count;
	logic [10:0] samples_per_frame;
	logic [11:0] payload_bytes;

	modport source(output valid, output valid_res, output layer_num, output version_code,
		output crc_present, output bitrate_kbps, output sample_rate_hz, output padded,
		output channel_mode, output mode_extension, output channel_count,
		output samples_per_frame, output payload_bytes, input ready);
	modport sink(input valid, input valid_res, input layer_num, input version_code,
		input crc_present, input bitrate_kbps, input sample_rate_hz, input padded,
		input channel_mode, input mode_extension, input channel_count,
		input samples_per_frame, input payload_bytes, output ready);
endinterface

// ----- hw/rtl/mahd_front.sv -----
// ---------------------------------------------------------------------------
// mahd_front
// Accepts header beats, validates them and decodes the fields and divide job.
// ---------------------------------------------------------------------------
module mahd_front (
	mahd_hdr_if.sink        hdr,
	input  logic            room,
	output logic            push,
	output mahd_pkg::item_t item
);

	logic [31:0] w;
	logic [1:0]  lc, ver, sri, lidx, sh;
	logic [3:0]  bri;
	logic        ok, mpeg1, l1;
	logic [8:0]  br;
	logic [7:0]  kmul;
	logic [18:0] num_full;
	mahd_pkg::div_sel_t dsel;

	assign hdr.ready = room;
	assign push      = hdr.valid && room;

	assign w   = hdr.header_word;
	assign ver = w[20:19];
	assign lc  = w[18:17];
	assign bri = w[15:12];
	assign sri = w[11:10];

	assign ok = (&w[31:21]) && (lc != mahd_pkg::LC_RSVD) && (bri != mahd_pkg::BRI_BAD)
		&& (ver != mahd_pkg::VER_RSVD) && (sri != mahd_pkg::SRI_RSVD)
		&& (bri != mahd_pkg::BRI_FREE);

	assign mpeg1 = (ver == mahd_pkg::VER_1);
	// layer-1 as table row; reserved code parks on row 0
	assign lidx  = (lc == mahd_pkg::LC_RSVD) ? 2'd0 : 2'(2'd3 - lc);
	assign l1    = (lidx == 2'd0);
	assign br    = mahd_pkg::BR_TAB[mpeg1][lidx][bri];

	always_comb begin
		priority if (ver == mahd_pkg::VER_1) begin
			sh = 2'd0;
		end else if (ver == mahd_pkg::VER_2) begin
			sh = 2'd1;
		end else begin
			sh = 2'd2;
		end
	end

	// reduced ratio of 12000 (or 144000) over the base rate
	always_comb begin
		unique case ({l1, sri})
			3'b100:  begin kmul = 8'd40;  dsel = mahd_pkg::DIV_147; end
			3'b101:  begin kmul = 8'd1;   dsel = mahd_pkg::DIV_4;   end
			3'b110:  begin kmul = 8'd3;   dsel = mahd_pkg::DIV_8;   end
			3'b000:  begin kmul = 8'd160; dsel = mahd_pkg::DIV_49;  end
			3'b001:  begin kmul = 8'd3;   dsel = mahd_pkg::DIV_1;   end
			3'b010:  begin kmul = 8'd9;   dsel = mahd_pkg::DIV_2;   end
			default: begin kmul = 8'd0;   dsel = mahd_pkg::DIV_1;   end
		endcase
	end

	assign num_full = (19'(kmul) * 19'(br)) << sh;

	always_comb begin
		item      = '0;
		item.dsel = mahd_pkg::DIV_1;
		if (ok) begin
			item.ok      = 1'b1;
			item.layer   = 2'(lidx + 2'd1);
			item.version = ver;
			item.crc     = ~w[16];
			item.br      = br;
			item.sr      = mahd_pkg::SR_BASE[sri] >> sh;
			item.pad     = w[9];
			item.mode    = w[7:6];
			item.modeext = w[5:4];
			item.chans   = (w[7:6] == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
			item.l1      = l1;
			item.half    = (lidx == 2'd2) && !mpeg1;
			item.num     = num_full[mahd_pkg::NUM_W-1:0];
			item.dsel    = dsel;
			if (l1) begin
				item.spf = 11'd384;
			end else if (item.half) begin
				item.spf = 11'd576;
			end else begin
				item.spf = 11'd1152;
			end
		end
	end

endmodule

// ----- hw/rtl/mahd_queue.sv -----
// ---------------------------------------------------------------------------
// mahd_queue
// Two-entry queue of decoded headers between front and back.
// ---------------------------------------------------------------------------
module mahd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mahd_pkg::item_t push_item,
	output logic            room,
	output logic            pop_valid,
	output mahd_pkg::item_t pop_item,
	input  logic            pop
);

	mahd_pkg::item_t mem_q [2];
	logic            wr_ptr_q, rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_pop;

	assign room      = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= 2'(cnt_q + 2'd1);
				2'b01:   cnt_q <= 2'(cnt_q - 2'd1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/mahd_back.sv -----
// ---------------------------------------------------------------------------
// mahd_back
// Reciprocal-multiply divider pipeline and result register for frame length.
// ---------------------------------------------------------------------------
module mahd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  mahd_pkg::item_t q_item,
	output logic            q_ready,
	mahd_res_if.source      res
);

	localparam int PW = mahd_pkg::PROD_W;
	localparam int QW = mahd_pkg::QUO_W;
	localparam int SH = mahd_pkg::RECIP_SH;

	logic            v_s1, v_s2, out_v_q;
	mahd_pkg::item_t it_s1, it_s2;
	logic [PW-1:0]   prod_s1;
	logic [QW-1:0]   quo_s2;
	logic            rdy1, rdy2, rdy3;

	logic [PW-1:0]   prod_d;
	logic [QW-1:0]   q_est, q_fix, q_half;
	logic [7:0]      dv;
	logic [19:0]     qd, rem;
	logic [11:0]     fb;

	// stall chain, output side first
	assign rdy3    = !out_v_q || res.ready;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign q_ready = rdy1;

	assign prod_d = PW'(q_item.num) * PW'(mahd_pkg::div_recip(q_item.dsel));

	// estimate is low by at most one
	assign dv    = mahd_pkg::div_val(it_s1.dsel);
	assign q_est = prod_s1[SH+QW-1:SH];
	assign qd    = 20'(q_est) * 20'(dv);
	assign rem   = 20'(it_s1.num) - qd;
	assign q_fix = (rem >= 20'(dv)) ? QW'(q_est + 1'b1) : q_est;

	assign q_half = it_s2.half ? (quo_s2 >> 1) : quo_s2;

	always_comb begin
		if (!it_s2.ok) begin
			fb = 12'd0;
		end else if (it_s2.l1) begin
			fb = 12'(((q_half + 12'(it_s2.pad)) << 2) - 12'd4);
		end else begin
			fb = 12'(q_half + 12'(it_s2.pad) - 12'd4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= q_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				out_v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && q_valid) begin
			it_s1   <= q_item;
			prod_s1 <= prod_d;
		end
		if (rdy2 && v_s1) begin
			it_s2  <= it_s1;
			quo_s2 <= q_fix;
		end
		if (rdy3 && v_s2) begin
			res.valid_res         <= it_s2.ok;
			res.layer_num         <= it_s2.layer;
			res.version_code      <= it_s2.version;
			res.crc_present       <= it_s2.crc;
			res.bitrate_kbps      <= it_s2.br;
			res.sample_rate_hz    <= it_s2.sr;
			res.padded            <= it_s2.pad;
			res.channel_mode      <= it_s2.mode;
			res.mode_extension    <= it_s2.modeext;
			res.channel_count     <= it_s2.chans;
			res.samples_per_frame <= it_s2.spf;
			res.payload_bytes     <= fb;
		end
	end

	assign res.valid = out_v_q;

endmodule

// ----- hw/rtl/mpeg_audio_header_decode.sv -----
// ---------------------------------------------------------------------------
// mpeg_audio_header_decode
// MPEG-1/2/2.5 audio frame header parser with frame length computation.
// ---------------------------------------------------------------------------
// One 32-bit header word per beat on hdr, one decoded result per beat on res,
// in order. The block takes a new header every clock while the queue has room;
// a result passes the queue entry, the multiply stage, the correct stage and the
// result register. The length divider is fully pipelined: the rate-to-bitrate
// ratio reduces to a divide by 1, 2, 4, 8, 49 or 147, done as a multiply by a
// 25-bit reciprocal in one stage and a single compare-and-correct in the next.
// A two-entry queue sits between the decode front and the divider back, and the
// result register lets a new header in while a finished result waits. Rejected
// headers (bad sync, reserved layer/version/rate, free-format or bad bitrate)
// still produce a result beat, with valid_res and every other field zero.
// Reset is asynchronous and clears only control state; no setup is needed.
module mpeg_audio_header_decode (
	input  logic       clk,
	input  logic       arst_n,
	mahd_hdr_if.sink   hdr,
	mahd_res_if.source res
);

	logic            push, room;
	logic            pop_valid, pop;
	mahd_pkg::item_t push_item, pop_item;

	// validate and classify
	mahd_front u_front (
		.hdr  (hdr),
		.room (room),
		.push (push),
		.item (push_item)
	);

	// decouples decode from divider stalls
	mahd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.room      (room),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop)
	);

	// divide, finish frame length, hold result
	mahd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_item  (pop_item),
		.q_ready (pop),
		.res     (res)
	);

endmodule

// ----- hw/rtl/mahd_checker.sv -----
// ---------------------------------------------------------------------------
// mahd_checker
// Port-level checks on the decoder result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mahd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_ready,
	input logic        valid_res,
	input logic [1:0]  layer_num,
	input logic [1:0]  channel_mode,
	input logic [1:0]  channel_count,
	input logic [10:0] samples_per_frame,
	input logic [11:0] payload_bytes
);

	`MAHD_ASSERT_HOLD(a_res_hold, clk, arst_n, res_valid, res_ready)

	`MAHD_ASSERT(a_reject_zero, clk, arst_n, (res_valid && !valid_res) |-> (layer_num == 2'd0 && channel_count == 2'd0 && samples_per_frame == 11'd0 && payload_bytes == 12'd0))

	`MAHD_ASSERT(a_chan_count, clk, arst_n, (res_valid && valid_res) |-> (layer_num != 2'd0 && ((channel_mode == mahd_pkg::MODE_MONO && channel_count == 2'd1) || (channel_mode != mahd_pkg::MODE_MONO && channel_count == 2'd2))))

	`MAHD_ASSERT(a_l1_spf, clk, arst_n, (res_valid && valid_res && layer_num == mahd_pkg::LAYER_1) |-> (samples_per_frame == 11'd384 && payload_bytes[1:0] == 2'd0))

endmodule

bind mpeg_audio_header_decode mahd_checker u_mahd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.valid_res         (res.valid_res),
	.layer_num         (res.layer_num),
	.channel_mode      (res.channel_mode),
	.channel_count     (res.channel_count),
	.samples_per_frame (res.samples_per_frame),
	.payload_bytes     (res.payload_bytes)
);
